@@ hw/rtl/dftbmp_pkg.sv @@
package dftbmp_pkg;

    // Frame and bin geometry (SAMPLES must be a power of two)
    localparam int BINS    = 32;
    localparam int SAMPLES = 256;
    localparam int ADDR_W  = $clog2(SAMPLES);
    localparam int BIN_W   = 6;

    // Twiddle factors, signed Q2.30
    localparam int TW_W = 32;

    // CORDIC constants, angles as a full turn of 2^32
    localparam int CORDIC_STEPS = 16;
    localparam int CS_W         = $clog2(CORDIC_STEPS);
    localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;

    // log2(11) in Q20
    localparam logic [21:0] LOG2_11_Q20 = 22'd3627477;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [31:0] t_angle_tab [CORDIC_STEPS];

    localparam t_angle_tab ATAN_TURN32 = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef logic signed [TW_W-1:0] t_tw_tab [SAMPLES];

    // One bin's normalized sums, handed from front to back
    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } t_bin_res;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [1:0] {
        FE_LOAD,
        FE_ISSUE,
        FE_DRAIN,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SQ,
        BK_SQRT,
        BK_ATAN,
        BK_GAIN,
        BK_LOGI,
        BK_LOG,
        BK_DIV,
        BK_FIN,
        BK_OUT
    } t_bk_state;

    // Rotation CORDIC of exp(-j*2*pi*n/SAMPLES) for every n, evaluated at elaboration
    function automatic t_tw_tab build_twiddle(input logic want_sin);
        t_tw_tab tab;
        longint  t;
        longint  theta;
        longint  x;
        longint  y;
        longint  z;
        longint  dx;
        longint  dy;
        logic    flip;
        for (int n = 0; n < SAMPLES; n++) begin
            t     = (longint'(n) <<< 32) / SAMPLES;
            theta = ((longint'(1) <<< 32) - t) & 64'hFFFF_FFFF;
            flip  = ((theta + 64'h4000_0000) & 64'h8000_0000) != 0;
            if (flip) begin
                theta = (theta - 64'h8000_0000) & 64'hFFFF_FFFF;
            end
            z = theta;
            if (theta >= 64'h8000_0000) begin
                z = z - (longint'(1) <<< 32);
            end
            x = longint'(CORDIC_K_Q30);
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_TURN32[i]);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_TURN32[i]);
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            tab[n] = want_sin ? TW_W'(y) : TW_W'(x);
        end
        return tab;
    endfunction

    localparam t_tw_tab COS_TAB = build_twiddle(1'b0);
    localparam t_tw_tab SIN_TAB = build_twiddle(1'b1);

endpackage

@@ hw/rtl/dftbmp_front.sv @@
module dftbmp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sample_valid,
    output logic                  o_sample_ready,
    input  logic signed [15:0]    i_sample,
    output logic                  o_push,
    output dftbmp_pkg::t_bin_res  o_push_data,
    input  dftbmp_pkg::t_q_stat   i_q_stat
);

    localparam int ADDR_W  = dftbmp_pkg::ADDR_W;
    localparam int BIN_W   = dftbmp_pkg::BIN_W;
    localparam int PROD_W  = 16 + dftbmp_pkg::TW_W;
    localparam int ACC_W   = PROD_W + ADDR_W;
    localparam int NORM_SH = ADDR_W + 30;
    localparam logic [ADDR_W-1:0] LAST_N   = ADDR_W'(dftbmp_pkg::SAMPLES - 1);
    localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(dftbmp_pkg::BINS - 1);

    logic signed [15:0] r_mem [dftbmp_pkg::SAMPLES];

    dftbmp_pkg::t_fe_state r_state, n_state;
    logic [ADDR_W-1:0]     r_cnt, n_cnt;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [BIN_W-1:0]      r_k, n_k;
    logic                  r_v1, r_v2;
    logic [ADDR_W-1:0]     r_idx1;
    logic signed [15:0]    r_rd;
    logic signed [PROD_W-1:0] r_p_re, r_p_im;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic                  issue;
    logic                  acc_clr;
    logic                  load_xfer;

    // Divide by the frame length, round half away from zero, saturate
    function automatic logic signed [15:0] norm_part(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        logic signed [15:0] res;
        mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        r   = (mag + (ACC_W'(1) << (NORM_SH - 1))) >> NORM_SH;
        if (acc[ACC_W-1]) begin
            res = (r > ACC_W'(32768)) ? 16'sh8000 : 16'(-r);
        end else begin
            res = (r > ACC_W'(32767)) ? 16'sh7FFF : 16'(r);
        end
        return res;
    endfunction

    // Next state: load frame, issue MACs per bin, drain, hand bin to queue
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_idx          = r_idx;
        n_k            = r_k;
        issue          = 1'b0;
        acc_clr        = 1'b0;
        o_push         = 1'b0;
        o_sample_ready = 1'b0;
        unique case (r_state)
            dftbmp_pkg::FE_LOAD: begin
                o_sample_ready = 1'b1;
                if (i_sample_valid) begin
                    if (r_cnt == LAST_N) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_k     = '0;
                        acc_clr = 1'b1;
                        n_state = dftbmp_pkg::FE_ISSUE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            dftbmp_pkg::FE_ISSUE: begin
                issue = 1'b1;
                n_idx = r_idx + ADDR_W'(r_k);
                if (r_cnt == LAST_N) begin
                    n_cnt   = '0;
                    n_state = dftbmp_pkg::FE_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dftbmp_pkg::FE_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = dftbmp_pkg::FE_PUSH;
                end
            end
            dftbmp_pkg::FE_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push  = 1'b1;
                    n_idx   = '0;
                    acc_clr = 1'b1;
                    if (r_k == LAST_BIN) begin
                        n_state = dftbmp_pkg::FE_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = dftbmp_pkg::FE_ISSUE;
                    end
                end
            end
            default: n_state = dftbmp_pkg::FE_LOAD;
        endcase
    end

    assign load_xfer = o_sample_ready && i_sample_valid;

    always_comb begin
        o_push_data.bin  = r_k;
        o_push_data.re   = norm_part(r_acc_re);
        o_push_data.im   = norm_part(r_acc_im);
        o_push_data.last = (r_k == LAST_BIN);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dftbmp_pkg::FE_LOAD;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_k     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_k     <= n_k;
            r_v1    <= issue;
            r_v2    <= r_v1;
        end
    end

    // Sample store: write on transfer, registered read for the MAC
    always_ff @(posedge i_clk) begin
        if (load_xfer) begin
            r_mem[r_cnt] <= i_sample;
        end
        r_rd <= r_mem[r_cnt];
    end

    // Twiddle multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_idx;
        r_p_re <= r_rd * dftbmp_pkg::COS_TAB[r_idx1];
        r_p_im <= r_rd * dftbmp_pkg::SIN_TAB[r_idx1];
        if (acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_re);
            r_acc_im <= r_acc_im + ACC_W'(r_p_im);
        end
    end

endmodule

@@ hw/rtl/dftbmp_fifo.sv @@
module dftbmp_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dftbmp_pkg::t_bin_res  i_push_data,
    input  logic                  i_pop,
    output dftbmp_pkg::t_bin_res  o_pop_data,
    output dftbmp_pkg::t_q_stat   o_stat
);

    localparam int PTR_W = dftbmp_pkg::Q_PTR_W;
    localparam int CNT_W = dftbmp_pkg::Q_CNT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(dftbmp_pkg::Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(dftbmp_pkg::Q_DEPTH);

    dftbmp_pkg::t_bin_res r_slot [dftbmp_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_pop_data   = r_slot[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Hold slot data
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue fill level out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_fill_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("fill level did not advance on push");

endmodule

@@ hw/rtl/dftbmp_back.sv @@
module dftbmp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dftbmp_pkg::t_q_stat   i_q_stat,
    output logic                  o_pop,
    input  dftbmp_pkg::t_bin_res  i_pop_data,
    input  logic [15:0]           i_sensitivity,
    output logic                  o_result_valid,
    input  logic                  i_result_ready,
    output logic [5:0]            o_bin_index,
    output logic signed [15:0]    o_real_part,
    output logic signed [15:0]    o_imag_part,
    output logic [14:0]           o_magnitude,
    output logic signed [15:0]    o_phase,
    output logic [15:0]           o_intensity,
    output logic                  o_last_bin
);

    localparam int STEP_W     = 6;
    localparam int CX_W       = 34;
    localparam int CS_W       = dftbmp_pkg::CS_W;
    localparam int SQRT_STEPS = 16;
    localparam int LOG_STEPS  = 20;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_S      = 36;
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
    localparam logic [STEP_W-1:0] ATAN_LAST = STEP_W'(dftbmp_pkg::CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] LOG_LAST  = STEP_W'(LOG_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_MUL   = STEP_W'(0);
    localparam logic [STEP_W-1:0] DIV_EST   = STEP_W'(1);
    localparam logic [STEP_W-1:0] DIV_REM   = STEP_W'(2);
    localparam logic [STEP_W-1:0] DIV_FIX   = STEP_W'(3);
    localparam logic [35:0] LOG_ONE = 36'd8388608;
    localparam logic [35:0] LOG_SAT = 36'd92274688;
    localparam logic [21:0] DIV_D   = dftbmp_pkg::LOG2_11_Q20;
    localparam logic [23:0] DIV_D1  = 24'(dftbmp_pkg::LOG2_11_Q20);
    localparam logic [23:0] DIV_D2  = 24'(dftbmp_pkg::LOG2_11_Q20) << 1;
    localparam logic [39:0] DIV_HALF = 40'(dftbmp_pkg::LOG2_11_Q20 / 2);
    localparam logic [30:0] DIV_M   =
        31'((64'd1 << (DIV_S + 16)) / 64'(dftbmp_pkg::LOG2_11_Q20));

    dftbmp_pkg::t_bk_state r_state, n_state;
    logic [STEP_W-1:0]     r_step, n_step;

    logic [5:0]            r_bin;
    logic signed [15:0]    r_re, r_im;
    logic                  r_last;
    logic [31:0]           r_v, r_res, r_bit;
    logic [14:0]           r_mag;
    logic signed [CX_W-1:0] r_x, r_y;
    logic [31:0]           r_z;
    logic [15:0]           r_phase;
    logic [30:0]           r_ms;
    logic [1:0]            r_e;
    logic [31:0]           r_ly;
    logic [19:0]           r_frac;
    logic [39:0]           r_num;
    logic [21:0]           r_l;
    logic [52:0]           r_p;
    logic [23:0]           r_rem;
    logic [17:0]           r_q;
    logic [15:0]           r_int;

    logic signed [31:0]    w_re2, w_im2;
    logic [31:0]           w_trial;
    logic [14:0]           w_mag;
    logic signed [CX_W-1:0] w_x0, w_y0, w_dx, w_dy;
    logic [35:0]           w_a;
    logic [1:0]            w_e;
    logic [42:0]           w_a7;
    logic [63:0]           w_p;
    logic [31:0]           w_yy;
    logic [19:0]           w_frac;
    logic [39:0]           w_qd;

    // Next state: pop, root, angle if im != 0, gain, log and divide if unsaturated
    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_pop          = 1'b0;
        o_result_valid = 1'b0;
        unique case (r_state)
            dftbmp_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = dftbmp_pkg::BK_SQ;
                end
            end
            dftbmp_pkg::BK_SQ: begin
                n_step  = '0;
                n_state = dftbmp_pkg::BK_SQRT;
            end
            dftbmp_pkg::BK_SQRT: begin
                if (r_step == SQRT_LAST) begin
                    n_step  = '0;
                    n_state = (r_im == 16'sd0) ? dftbmp_pkg::BK_GAIN : dftbmp_pkg::BK_ATAN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            dftbmp_pkg::BK_ATAN: begin
                if (r_step == ATAN_LAST) begin
                    n_step  = '0;
                    n_state = dftbmp_pkg::BK_GAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            dftbmp_pkg::BK_GAIN: n_state = dftbmp_pkg::BK_LOGI;
            dftbmp_pkg::BK_LOGI: begin
                n_step  = '0;
                n_state = (w_a >= LOG_SAT) ? dftbmp_pkg::BK_OUT : dftbmp_pkg::BK_LOG;
            end
            dftbmp_pkg::BK_LOG: begin
                if (r_step == LOG_LAST) begin
                    n_step  = '0;
                    n_state = dftbmp_pkg::BK_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            dftbmp_pkg::BK_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = dftbmp_pkg::BK_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            dftbmp_pkg::BK_FIN: n_state = dftbmp_pkg::BK_OUT;
            dftbmp_pkg::BK_OUT: begin
                o_result_valid = 1'b1;
                if (i_result_ready) begin
                    n_state = dftbmp_pkg::BK_IDLE;
                end
            end
            default: n_state = dftbmp_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dftbmp_pkg::BK_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Datapath helpers
    assign w_re2   = r_re * r_re;
    assign w_im2   = r_im * r_im;
    assign w_trial = r_res + r_bit;
    assign w_mag   = (r_res > 32'd32767) ? 15'h7FFF : r_res[14:0];
    assign w_x0    = {{(CX_W - 30){r_re[15]}}, r_re, 14'b0};
    assign w_y0    = {{(CX_W - 30){r_im[15]}}, r_im, 14'b0};
    assign w_dx    = r_y >>> r_step[CS_W-1:0];
    assign w_dy    = r_x >>> r_step[CS_W-1:0];
    assign w_a     = LOG_ONE + (36'(r_ms) << 3) + (36'(r_ms) << 1);
    assign w_e     = (w_a >= 36'd67108864) ? 2'd3 :
                     (w_a >= 36'd33554432) ? 2'd2 :
                     (w_a >= 36'd16777216) ? 2'd1 : 2'd0;
    assign w_a7    = {w_a[35:0], 7'b0};
    assign w_p     = r_ly * r_ly;
    assign w_yy    = w_p[61:30];
    assign w_frac  = {r_frac[18:0], w_yy[31]};
    assign w_qd    = r_q * DIV_D;

    // Per-state datapath updates
    always_ff @(posedge i_clk) begin
        case (r_state)
            dftbmp_pkg::BK_IDLE: begin
                if (o_pop) begin
                    r_bin  <= i_pop_data.bin;
                    r_re   <= i_pop_data.re;
                    r_im   <= i_pop_data.im;
                    r_last <= i_pop_data.last;
                end
            end
            dftbmp_pkg::BK_SQ: begin
                r_v   <= $unsigned(w_re2) + $unsigned(w_im2);
                r_res <= '0;
                r_bit <= 32'h4000_0000;
                // Seed the vectoring rotation; an exact real axis needs no rotation
                if (r_im == 16'sd0) begin
                    r_z <= r_re[15] ? 32'h8000_0000 : 32'h0;
                end else if (r_re[15]) begin
                    r_x <= -w_x0;
                    r_y <= -w_y0;
                    r_z <= 32'h8000_0000;
                end else begin
                    r_x <= w_x0;
                    r_y <= w_y0;
                    r_z <= 32'h0;
                end
            end
            dftbmp_pkg::BK_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            dftbmp_pkg::BK_ATAN: begin
                if (!r_y[CX_W-1]) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + dftbmp_pkg::ATAN_TURN32[r_step[CS_W-1:0]];
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - dftbmp_pkg::ATAN_TURN32[r_step[CS_W-1:0]];
                end
            end
            dftbmp_pkg::BK_GAIN: begin
                r_mag   <= w_mag;
                r_phase <= 16'((r_z + 32'h8000) >> 16);
                r_ms    <= w_mag * i_sensitivity;
            end
            dftbmp_pkg::BK_LOGI: begin
                r_e    <= w_e;
                r_ly   <= 32'(w_a7 >> w_e);
                r_frac <= '0;
                if (w_a >= LOG_SAT) begin
                    r_int <= 16'hFFFF;
                end
            end
            dftbmp_pkg::BK_LOG: begin
                r_frac <= w_frac;
                r_ly   <= w_yy[31] ? (w_yy >> 1) : w_yy;
                if (r_step == LOG_LAST) begin
                    r_num <= ({18'b0, r_e, w_frac} << 16) + DIV_HALF;
                    r_l   <= {r_e, w_frac};
                    r_rem <= '0;
                    r_q   <= '0;
                end
            end
            // Reciprocal estimate of the quotient, then fix it up by the remainder
            dftbmp_pkg::BK_DIV: begin
                case (r_step)
                    DIV_MUL: r_p <= r_l * DIV_M;
                    DIV_EST: r_q <= 18'(r_p >> DIV_S);
                    DIV_REM: r_rem <= 24'(r_num - w_qd);
                    DIV_FIX: begin
                        if (r_rem >= DIV_D2) begin
                            r_q <= r_q + 18'd2;
                        end else if (r_rem >= DIV_D1) begin
                            r_q <= r_q + 18'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dftbmp_pkg::BK_FIN: begin
                r_int <= (r_q > 18'd65535) ? 16'hFFFF : r_q[15:0];
            end
            default: begin
            end
        endcase
    end

    assign o_bin_index = r_bin;
    assign o_real_part = r_re;
    assign o_imag_part = r_im;
    assign o_magnitude = r_mag;
    assign o_phase     = r_phase;
    assign o_intensity = r_int;
    assign o_last_bin  = r_last;

endmodule

@@ hw/rtl/dft_bin_magnitude_phase_core.sv @@
// Frame load: one sample transfer per cycle until SAMPLES samples are in.
// DFT: each bin is summed over all SAMPLES samples on the single complex MAC, and
// no new frame's samples are taken until every bin of the frame has been pushed.
// Bins pass through a queue to the post-processing unit (root, CORDIC angle, log, divide).
// Reset (synchronous, active low) clears control and sets sensitivity to 1.0; samples are not cleared.
module dft_bin_magnitude_phase_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sample_valid,
    output logic               o_sample_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [5:0]         o_bin_index,
    output logic signed [15:0] o_real_part,
    output logic signed [15:0] o_imag_part,
    output logic [14:0]        o_magnitude,
    output logic signed [15:0] o_phase,
    output logic [15:0]        o_intensity,
    output logic               o_last_bin
);

    logic [15:0]          r_sensitivity;
    logic                 push;
    logic                 pop;
    dftbmp_pkg::t_bin_res push_data;
    dftbmp_pkg::t_bin_res pop_data;
    dftbmp_pkg::t_q_stat  q_stat;

    // Sensitivity register, unsigned Q8.8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensitivity <= 16'd256;
        end else if (i_cfg_we) begin
            r_sensitivity <= i_cfg_data;
        end
    end

    dftbmp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_push         (push),
        .o_push_data    (push_data),
        .i_q_stat       (q_stat)
    );

    dftbmp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    dftbmp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_pop_data     (pop_data),
        .i_sensitivity  (r_sensitivity),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_bin_index    (o_bin_index),
        .o_real_part    (o_real_part),
        .o_imag_part    (o_imag_part),
        .o_magnitude    (o_magnitude),
        .o_phase        (o_phase),
        .o_intensity    (o_intensity),
        .o_last_bin     (o_last_bin)
    );

endmodule
